// File: design/wps_pkg.sv
`default_nettype none

package wps_pkg;

    // field and datapath widths
    localparam int CIRC_W     = 12;
    localparam int MAG_W      = 8;
    localparam int MIN_W      = 15;
    localparam int SPD_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 40;
    localparam int DIST_W     = 48;
    localparam int PROD_W     = CNT_W + CIRC_W;
    localparam int CMD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // shared divider: dividend up to circ*1000 < 2^22, divisor up to dt*magnets < 2^40
    localparam int DIVN_W    = 22;
    localparam int DIVD_W    = TIME_W + MAG_W;
    localparam int DIV_CNT_W = $clog2(DIVN_W + 1);

    // 99 km/h interval: circ*3.6/99 ms = floor(2*circ/55)
    // 19066 = 2*ceil(2^19/55); exact for every 12-bit circumference
    localparam int MIN_IV_SHIFT = 19;
    localparam int MIN_IV_W     = CIRC_W + 15;
    localparam logic [MIN_IV_W-1:0] MIN_IV_RECIP = MIN_IV_W'(19066);
    localparam logic [DIVN_W-1:0]   MS_PER_S     = DIVN_W'(1000);

    localparam logic [SPD_W-1:0]  SPEED_MAX = '1;
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PULSE      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START_TRIP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP_TRIP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET_TRIP = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CIRC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNETS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SPD = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEN,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_DIST,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic [CIRC_W-1:0] circ;
        logic [MAG_W-1:0]  magnets;
        logic [MIN_W-1:0]  stop_spd;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] now_ms;
        logic              clear_moving_time;
        logic              clear_total_distance;
    } item_t;

    typedef struct packed {
        logic              pulse_accepted;
        logic [SPD_W-1:0]  speed_mmps;
        logic [DIST_W-1:0] trip_distance_mm;
        logic [DIST_W-1:0] total_distance_mm;
        logic [CNT_W-1:0]  moving_time_ms;
    } res_t;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIVD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVN_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [SPD_W-1:0] sat_speed(input logic [DIVN_W-1:0] q);
        sat_speed = (|q[DIVN_W-1:SPD_W]) ? SPEED_MAX : q[SPD_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] sat_dist(input logic [PROD_W-1:0] p);
        sat_dist = (|p[PROD_W-1:DIST_W]) ? DIST_MAX : p[DIST_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/wps_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module wps_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire wps_pkg::div_req_t   req,
    output wps_pkg::div_rsp_t        rsp
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [wps_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [wps_pkg::DIVN_W:0]           rem_reg, rem_next;
    logic [wps_pkg::DIVN_W-1:0]         quo_reg, quo_next;
    logic [wps_pkg::DIVD_W-1:0]         dvs_reg, dvs_next;

    logic [wps_pkg::DIVN_W:0]           shifted;
    logic                               fits;

    // divisor zero: every step fits, quotient all ones, saturates later
    assign shifted = {rem_reg[wps_pkg::DIVN_W-1:0], quo_reg[wps_pkg::DIVN_W-1]};
    assign fits    = {{(wps_pkg::DIVD_W-wps_pkg::DIVN_W-1){1'b0}}, shifted} >= dvs_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = wps_pkg::DIV_CNT_W'(wps_pkg::DIVN_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = shifted - dvs_reg[wps_pkg::DIVN_W:0];
            end else begin
                rem_next = shifted;
            end
            quo_next = {quo_reg[wps_pkg::DIVN_W-2:0], fits};
            cnt_next = cnt_reg - wps_pkg::DIV_CNT_W'(1);
            if (cnt_reg == wps_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with empty step count");

endmodule

`default_nettype wire

// File: design/wps_seq.sv
`default_nettype none

// command sequencer and speedometer state
module wps_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire wps_pkg::cfg_t       cfg,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire wps_pkg::item_t      item,
    input  wire logic                out_free,
    output logic                     res_valid,
    output wps_pkg::res_t            res,
    output wps_pkg::div_req_t        div_req,
    input  wire wps_pkg::div_rsp_t   div_rsp
);

    wps_pkg::seq_state_t state_reg, state_next;

    // request payload
    wps_pkg::item_t                 item_reg, item_next;
    logic [wps_pkg::TIME_W-1:0]     dt_reg, dt_next;
    logic [wps_pkg::DIVD_W-1:0]     den_reg, den_next;
    logic                           acc_reg, acc_next;
    logic [wps_pkg::SPD_W-1:0]      speed_reg, speed_next;
    logic [wps_pkg::PROD_W-1:0]     trip_prod_reg, trip_prod_next;
    logic [wps_pkg::PROD_W-1:0]     total_prod_reg, total_prod_next;

    // architectural state
    logic [wps_pkg::TIME_W-1:0]     last_pulse_reg, last_pulse_next;
    logic [wps_pkg::SPD_W-1:0]      held_speed_reg, held_speed_next;
    logic                           fresh_reg, fresh_next;
    logic                           trip_en_reg, trip_en_next;
    logic [wps_pkg::CNT_W-1:0]      trip_revs_reg, trip_revs_next;
    logic [wps_pkg::CNT_W-1:0]      total_revs_reg, total_revs_next;
    logic [wps_pkg::CNT_W-1:0]      moving_reg, moving_next;

    logic [wps_pkg::SPD_W-1:0]      q_sat;
    logic [wps_pkg::SPD_W-1:0]      est_min;
    logic [wps_pkg::SPD_W-1:0]      min_ext;
    logic [wps_pkg::MIN_IV_W-1:0]   min_iv_prod;
    logic [wps_pkg::MIN_IV_W-wps_pkg::MIN_IV_SHIFT-1:0] min_iv;

    assign q_sat   = wps_pkg::sat_speed(div_rsp.quotient);
    assign est_min = (q_sat < held_speed_reg) ? q_sat : held_speed_reg;
    assign min_ext = {1'b0, cfg.stop_spd};

    // 99 km/h filter interval by reciprocal multiply
    assign min_iv_prod = wps_pkg::MIN_IV_W'(cfg.circ) * wps_pkg::MIN_IV_RECIP;
    assign min_iv      = min_iv_prod[wps_pkg::MIN_IV_W-1:wps_pkg::MIN_IV_SHIFT];

    assign item_ready = (state_reg == wps_pkg::ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        dt_next         = dt_reg;
        den_next        = den_reg;
        acc_next        = acc_reg;
        speed_next      = speed_reg;
        trip_prod_next  = trip_prod_reg;
        total_prod_next = total_prod_reg;
        last_pulse_next = last_pulse_reg;
        held_speed_next = held_speed_reg;
        fresh_next      = fresh_reg;
        trip_en_next    = trip_en_reg;
        trip_revs_next  = trip_revs_reg;
        total_revs_next = total_revs_reg;
        moving_next     = moving_reg;
        div_req         = '0;
        res_valid       = 1'b0;

        unique case (state_reg)
            wps_pkg::ST_IDLE: begin
                if (item_valid) begin
                    item_next  = item;
                    dt_next    = item.now_ms - last_pulse_reg;
                    acc_next   = 1'b0;
                    speed_next = held_speed_reg;
                    state_next = wps_pkg::ST_DIST;
                    unique case (item.command)
                        wps_pkg::CMD_PULSE: begin
                            state_next = wps_pkg::ST_DEN;
                        end
                        wps_pkg::CMD_READ: begin
                            if (fresh_reg) begin
                                speed_next = (held_speed_reg >= min_ext) ? held_speed_reg : '0;
                                fresh_next = 1'b0;
                            end else begin
                                state_next = wps_pkg::ST_DEN;
                            end
                        end
                        wps_pkg::CMD_START_TRIP: begin
                            trip_en_next = 1'b1;
                        end
                        wps_pkg::CMD_STOP_TRIP: begin
                            trip_en_next = 1'b0;
                        end
                        wps_pkg::CMD_RESET_TRIP: begin
                            trip_en_next   = 1'b0;
                            trip_revs_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            wps_pkg::ST_DEN: begin
                den_next = wps_pkg::DIVD_W'(dt_reg) * wps_pkg::DIVD_W'(cfg.magnets);
                if (item_reg.command == wps_pkg::CMD_PULSE) begin
                    // too soon after the last pulse: rejected, no divide
                    state_next = (dt_reg >= wps_pkg::TIME_W'(min_iv)) ?
                                 wps_pkg::ST_SPD_GO : wps_pkg::ST_DIST;
                end else begin
                    state_next = wps_pkg::ST_SPD_GO;
                end
            end
            wps_pkg::ST_SPD_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = wps_pkg::DIVN_W'(cfg.circ) * wps_pkg::MS_PER_S;
                div_req.divisor  = den_reg;
                state_next       = wps_pkg::ST_SPD_WAIT;
            end
            wps_pkg::ST_SPD_WAIT: begin
                if (div_rsp.done) begin
                    state_next = wps_pkg::ST_DIST;
                    if (item_reg.command == wps_pkg::CMD_PULSE) begin
                        acc_next        = 1'b1;
                        speed_next      = q_sat;
                        held_speed_next = q_sat;
                        last_pulse_next = item_reg.now_ms;
                        fresh_next      = 1'b1;
                        total_revs_next = total_revs_reg + wps_pkg::CNT_W'(1);
                        if (trip_en_reg) begin
                            trip_revs_next = trip_revs_reg + wps_pkg::CNT_W'(1);
                        end
                        if (q_sat >= min_ext) begin
                            moving_next = moving_reg + wps_pkg::CNT_W'(dt_reg);
                        end
                    end else begin
                        speed_next = (est_min >= min_ext) ? est_min : '0;
                        fresh_next = 1'b0;
                    end
                end
            end
            wps_pkg::ST_DIST: begin
                trip_prod_next  = wps_pkg::PROD_W'(trip_revs_reg) *
                                  wps_pkg::PROD_W'(cfg.circ);
                total_prod_next = wps_pkg::PROD_W'(total_revs_reg) *
                                  wps_pkg::PROD_W'(cfg.circ);
                state_next      = wps_pkg::ST_RESULT;
            end
            wps_pkg::ST_RESULT: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = wps_pkg::ST_IDLE;
                    // clears land after the values were reported
                    if (item_reg.command == wps_pkg::CMD_READ) begin
                        if (item_reg.clear_moving_time) begin
                            moving_next = '0;
                        end
                        if (item_reg.clear_total_distance) begin
                            total_revs_next = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = wps_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.pulse_accepted    = acc_reg;
    assign res.speed_mmps        = speed_reg;
    assign res.trip_distance_mm  = wps_pkg::sat_dist(trip_prod_reg);
    assign res.total_distance_mm = wps_pkg::sat_dist(total_prod_reg);
    assign res.moving_time_ms    = moving_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wps_pkg::ST_IDLE;
            last_pulse_reg <= '0;
            held_speed_reg <= '0;
            fresh_reg      <= 1'b0;
            trip_en_reg    <= 1'b0;
            trip_revs_reg  <= '0;
            total_revs_reg <= '0;
            moving_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            last_pulse_reg <= last_pulse_next;
            held_speed_reg <= held_speed_next;
            fresh_reg      <= fresh_next;
            trip_en_reg    <= trip_en_next;
            trip_revs_reg  <= trip_revs_next;
            total_revs_reg <= total_revs_next;
            moving_reg     <= moving_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        dt_reg         <= dt_next;
        den_reg        <= den_next;
        acc_reg        <= acc_next;
        speed_reg      <= speed_next;
        trip_prod_reg  <= trip_prod_next;
        total_prod_reg <= total_prod_next;
    end

    a_fresh_from_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(fresh_reg) |-> item_reg.command == wps_pkg::CMD_PULSE)
        else $error("fresh pulse flag set by a non-pulse request");

    a_stamp_with_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(last_pulse_reg) |-> fresh_reg && acc_reg)
        else $error("pulse time moved without an accepted pulse");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == wps_pkg::ST_SPD_WAIT)
        else $error("divider result arrived outside a wait state");

endmodule

`default_nettype wire

// File: design/wheel_pulse_speedometer_top.sv
`default_nettype none

// Wheel pulse speedometer.
// Requests arrive on the s_ channel (valid/ready): a command (pulse, read,
// start/stop/reset trip), a millisecond timestamp and two clear flags for
// reads. Every accepted request yields exactly one result on the m_ channel:
// pulse accepted flag, speed in mm/s, trip and total distance in mm and
// moving time in ms.
// One shared restoring divider (one quotient bit a cycle, 22 steps) does the
// speed division under a small sequencer; the 99 km/h interval comes from a
// constant reciprocal multiply. The block takes one request at a time.
// s_ready drops while a request is in flight and returns the cycle after the
// result is loaded. The result sits in an output register; the next request
// is taken while it waits, and the sequencer holds its final step only if a
// new result is ready while m_ready is low. Config writes (cfg_*) are always
// ready; the user must write them only while idle, which the block itself
// does not enforce.
// Reset (aresetn, synchronous, active low) restores circumference 2000 mm,
// one magnet, minimum speed 1000 mm/s and clears all counters and flags.
module wheel_pulse_speedometer_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wps_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [wps_pkg::CMD_W-1:0]         s_command,
    input  wire logic [wps_pkg::TIME_W-1:0]        s_now_ms,
    input  wire logic                              s_clear_moving_time,
    input  wire logic                              s_clear_total_distance,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_pulse_accepted,
    output logic [wps_pkg::SPD_W-1:0]              m_speed_mmps,
    output logic [wps_pkg::DIST_W-1:0]             m_trip_distance_mm,
    output logic [wps_pkg::DIST_W-1:0]             m_total_distance_mm,
    output logic [wps_pkg::CNT_W-1:0]              m_moving_time_ms
);

    wps_pkg::cfg_t      cfg_reg, cfg_next;
    wps_pkg::item_t     item;
    wps_pkg::res_t      res;
    wps_pkg::res_t      out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;
    logic               res_valid;
    wps_pkg::div_req_t  div_req;
    wps_pkg::div_rsp_t  div_rsp;

    // ---------------- configuration registers ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                wps_pkg::REG_CIRC:     cfg_next.circ     = cfg_data[wps_pkg::CIRC_W-1:0];
                wps_pkg::REG_MAGNETS:  cfg_next.magnets  = cfg_data[wps_pkg::MAG_W-1:0];
                wps_pkg::REG_STOP_SPD: cfg_next.stop_spd = cfg_data[wps_pkg::MIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.circ     <= wps_pkg::CIRC_W'(2000);
            cfg_reg.magnets  <= wps_pkg::MAG_W'(1);
            cfg_reg.stop_spd <= wps_pkg::MIN_W'(1000);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- request into the sequencer ----------------
    assign item.command              = s_command;
    assign item.now_ms               = s_now_ms;
    assign item.clear_moving_time    = s_clear_moving_time;
    assign item.clear_total_distance = s_clear_total_distance;

    wps_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (s_valid),
        .item_ready (s_ready),
        .item       (item),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    wps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- output register ----------------
    // slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid) begin
            out_next       = res;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid             = out_valid_reg;
    assign m_pulse_accepted    = out_reg.pulse_accepted;
    assign m_speed_mmps        = out_reg.speed_mmps;
    assign m_trip_distance_mm  = out_reg.trip_distance_mm;
    assign m_total_distance_mm = out_reg.total_distance_mm;
    assign m_moving_time_ms    = out_reg.moving_time_ms;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !out_valid_reg || m_ready)
        else $error("result loaded over an undelivered one");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_res_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_ready)
        else $error("result produced with no request in flight");

endmodule

`default_nettype wire
